>>> rtl/iord_pkg.sv
`timescale 1ns / 1ps

package iord_pkg;

  // received item as it crosses the input channel
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } iord_in_t;

  // result item
  typedef struct packed {
    logic        frame_done;
    logic [7:0]  command;
    logic [7:0]  sync_number;
    logic [31:0] input_bits;
    logic [31:0] latch_bits;
    logic [31:0] output_bits;
    logic [15:0] response_ticks;
    logic        waiting;
  } iord_out_t;

  // operation codes on the input channel
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // classified work handed from front to back
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_header;
    logic [7:0] data;
  } iord_cmd_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // device types
  localparam logic [1:0] DEV_16IN_16OUT = 2'd0;
  localparam logic [1:0] DEV_16OUT      = 2'd1;
  localparam logic [1:0] DEV_32OUT      = 2'd2;

  // frame constants
  localparam logic [7:0] HDR_BYTE       = 8'hAA;
  localparam logic [7:0] CMD_GET_INPUT  = 8'hC0;
  localparam logic [7:0] CMD_GET_OUTPUT = 8'hC5;
  localparam logic [7:0] IO_REG_LEN     = 8'd12;
  localparam logic [7:0] MIN_FRAME_LEN  = 8'd4;
  localparam logic [7:0] LEN_OVERHEAD   = 8'd5;

  localparam int unsigned KEPT_DATA_BYTES = 8;
  localparam int unsigned KEPT_IDX_W      = $clog2(KEPT_DATA_BYTES);

  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd100;
  localparam int unsigned DEFAULT_TICK_W  = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> rtl/iord_front.sv
`timescale 1ns / 1ps

module iord_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iord_pkg::iord_in_t   in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output iord_pkg::iord_cmd_t  q_cmd
);

  // stall from the registered queue fill only
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.data      = in_data.rx_byte;
    q_cmd.is_header = (in_data.rx_byte == iord_pkg::HDR_BYTE);
    case (in_data.operation)
      iord_pkg::OP_BYTE:    q_cmd.kind = iord_pkg::KIND_BYTE;
      iord_pkg::OP_REQUEST: q_cmd.kind = iord_pkg::KIND_REQUEST;
      iord_pkg::OP_TICK:    q_cmd.kind = iord_pkg::KIND_TICK;
      default:              q_cmd.kind = iord_pkg::KIND_NOP;
    endcase
  end

endmodule

>>> rtl/iord_queue.sv
`timescale 1ns / 1ps

module iord_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  iord_pkg::iord_cmd_t  push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output iord_pkg::iord_cmd_t  head_cmd
);

  localparam int unsigned PtrW = (iord_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(iord_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(iord_pkg::QUEUE_DEPTH + 1);

  iord_pkg::iord_cmd_t mem_r [iord_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == CntW'(iord_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(iord_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/iord_back.sv
`timescale 1ns / 1ps

module iord_back #(
  parameter int unsigned TICK_WIDTH = iord_pkg::DEFAULT_TICK_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [iord_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iord_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              head_valid,
  input  iord_pkg::iord_cmd_t               head_cmd,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output iord_pkg::iord_out_t               out_data
);

  localparam int unsigned CmpW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
  localparam logic [TICK_WIDTH-1:0] TickMax = {TICK_WIDTH{1'b1}};

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_SYNC   = 3'd2;
  localparam logic [2:0] PH_RSV    = 3'd3;
  localparam logic [2:0] PH_CMD    = 3'd4;
  localparam logic [2:0] PH_STATUS = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;

  logic [1:0]  dev_type_r;
  logic [15:0] timeout_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  fcmd_r, fcmd_nxt;
  logic [7:0]  fsync_r, fsync_nxt;
  logic [8*iord_pkg::KEPT_DATA_BYTES-1:0] cap_r, cap_nxt;
  logic [31:0] in_word_r, in_word_nxt;
  logic [31:0] latch_r, latch_nxt;
  logic [31:0] outw_r, outw_nxt;
  logic [TICK_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_WIDTH-1:0] resp_r, resp_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  dcmd_r, dcmd_nxt;
  logic [7:0]  dsync_r, dsync_nxt;
  logic        done;
  logic [CmpW-1:0] resp_wide;

  logic                out_valid_r, out_valid_nxt;
  iord_pkg::iord_out_t out_data_r, out_data_nxt;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    len_nxt     = len_r;
    fcmd_nxt    = fcmd_r;
    fsync_nxt   = fsync_r;
    cap_nxt     = cap_r;
    in_word_nxt = in_word_r;
    latch_nxt   = latch_r;
    outw_nxt    = outw_r;
    elapsed_nxt = elapsed_r;
    resp_nxt    = resp_r;
    await_nxt   = await_r;
    dcmd_nxt    = dcmd_r;
    dsync_nxt   = dsync_r;
    done        = 1'b0;

    case (head_cmd.kind)
      iord_pkg::KIND_BYTE: begin
        case (phase_r)
          PH_LEN: begin
            len_nxt   = head_cmd.data;
            phase_nxt = PH_SYNC;
          end
          PH_SYNC: begin
            fsync_nxt = head_cmd.data;
            phase_nxt = PH_RSV;
          end
          PH_RSV: phase_nxt = PH_CMD;
          PH_CMD: begin
            fcmd_nxt  = head_cmd.data;
            phase_nxt = PH_STATUS;
          end
          PH_STATUS: begin
            // bad status or no data bytes drops the frame
            phase_nxt = (head_cmd.data != 8'd0 || len_r <= iord_pkg::MIN_FRAME_LEN) ?
                        PH_HUNT : PH_DATA;
          end
          PH_DATA: begin
            if (idx_r < 8'(iord_pkg::KEPT_DATA_BYTES)) begin
              cap_nxt[{idx_r[iord_pkg::KEPT_IDX_W-1:0], 3'b000} +: 8] =
                cap_r[{idx_r[iord_pkg::KEPT_IDX_W-1:0], 3'b000} +: 8] | head_cmd.data;
            end
            if ({1'b0, idx_r} + {1'b0, iord_pkg::LEN_OVERHEAD} == {1'b0, len_r}) begin
              done      = 1'b1;
              resp_nxt  = elapsed_r;
              await_nxt = 1'b0;
              phase_nxt = PH_HUNT;
              dcmd_nxt  = fcmd_r;
              dsync_nxt = fsync_r;
              if (len_r == iord_pkg::IO_REG_LEN) begin
                if (fcmd_r == iord_pkg::CMD_GET_INPUT) begin
                  in_word_nxt = cap_nxt[31:0];
                  latch_nxt   = cap_nxt[63:32];
                end else if (fcmd_r == iord_pkg::CMD_GET_OUTPUT) begin
                  if (dev_type_r == iord_pkg::DEV_16IN_16OUT) begin
                    outw_nxt = {cap_nxt[31:16], outw_r[15:0]};
                  end else if (dev_type_r == iord_pkg::DEV_16OUT ||
                               dev_type_r == iord_pkg::DEV_32OUT) begin
                    outw_nxt = cap_nxt[31:0];
                  end
                end
              end
            end else begin
              idx_nxt = idx_r + 8'd1;
            end
          end
          default: begin
            if (head_cmd.is_header) begin
              phase_nxt = PH_LEN;
              idx_nxt   = '0;
              cap_nxt   = '0;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        endcase
      end
      iord_pkg::KIND_REQUEST: begin
        elapsed_nxt = '0;
        await_nxt   = 1'b1;
      end
      iord_pkg::KIND_TICK: begin
        if (elapsed_r != TickMax) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
        if (CmpW'(elapsed_nxt) > CmpW'(timeout_r)) begin
          phase_nxt = PH_HUNT;
          await_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign resp_wide = CmpW'(resp_nxt);

  always_comb begin
    out_data_nxt.frame_done     = done;
    out_data_nxt.command        = dcmd_nxt;
    out_data_nxt.sync_number    = dsync_nxt;
    out_data_nxt.input_bits     = in_word_nxt;
    out_data_nxt.latch_bits     = latch_nxt;
    out_data_nxt.output_bits    = outw_nxt;
    out_data_nxt.response_ticks = (resp_wide > CmpW'(16'hFFFF)) ? 16'hFFFF : resp_wide[15:0];
    out_data_nxt.waiting        = await_nxt;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_type_r <= iord_pkg::DEV_32OUT;
      timeout_r  <= iord_pkg::DEFAULT_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        iord_pkg::CFG_DEVICE_TYPE:   dev_type_r <= cfg_data[1:0];
        iord_pkg::CFG_TIMEOUT_TICKS: timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      idx_r       <= '0;
      len_r       <= '0;
      fcmd_r      <= '0;
      fsync_r     <= '0;
      cap_r       <= '0;
      in_word_r   <= '0;
      latch_r     <= '0;
      outw_r      <= '0;
      elapsed_r   <= '0;
      resp_r      <= '0;
      await_r     <= 1'b0;
      dcmd_r      <= '0;
      dsync_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r   <= phase_nxt;
        idx_r     <= idx_nxt;
        len_r     <= len_nxt;
        fcmd_r    <= fcmd_nxt;
        fsync_r   <= fsync_nxt;
        cap_r     <= cap_nxt;
        in_word_r <= in_word_nxt;
        latch_r   <= latch_nxt;
        outw_r    <= outw_nxt;
        elapsed_r <= elapsed_nxt;
        resp_r    <= resp_nxt;
        await_r   <= await_nxt;
        dcmd_r    <= dcmd_nxt;
        dsync_r   <= dsync_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> rtl/io_module_response_deframer.sv
`timescale 1ns / 1ps
// throughput: one item per clock while no held result is stalled, set by the parse step in the back end
// path: an accepted item is stored in the queue register, then its result in the output register
// a two-entry queue between front and back takes two more items while a result is held,
// then the input stalls
// reset (rst_n low, synchronous): parser in header hunt, all words and counters zero,
// device type 2 and timeout 100 ticks; no items are in flight afterwards
module io_module_response_deframer #(
  parameter int unsigned TICK_WIDTH = iord_pkg::DEFAULT_TICK_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  iord_pkg::iord_in_t               in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output iord_pkg::iord_out_t              out_data,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iord_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iord_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // front to queue
  logic                q_push;
  logic                q_full;
  iord_pkg::iord_cmd_t q_cmd;

  // queue to back
  logic                head_valid;
  iord_pkg::iord_cmd_t head_cmd;
  logic                pop;

  // config writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // front: decode the operation and flag the header byte
  iord_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // short queue decoupling the two sides
  iord_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: frame parser, tick timer, word update and result register
  iord_back #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> rtl/iord_checker.sv
`timescale 1ns / 1ps

module iord_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input iord_pkg::iord_out_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a completed frame ends the wait
  a_done_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.waiting)
    else $error("waiting still set on completed frame");

endmodule

bind io_module_response_deframer iord_checker u_iord_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
